### design/fac_pkg.sv
// Shared types and constants for the frame allocator with clock replacement.
`default_nettype none
package fac_pkg;

	localparam int NUM_FRAMES_DEF = 64;
	localparam int FRAME_W        = 6;
	localparam int CMD_W          = 2;

	localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_MARK  = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [FRAME_W-1:0] frame_index;
	} req_t;

	typedef struct packed {
		logic [FRAME_W-1:0] granted_frame;
		logic               evicted;
	} rsp_t;

	typedef struct packed {
		logic used;
		logic refd;
	} ent_t;

endpackage
`default_nettype wire

### design/frame_alloc_clock_replacement.sv
// Top level: frame pool allocator with clock (second-chance) replacement.
// Free and mark pass through a look state that reads the frame entry; an unknown command
// or out-of-range frame completes from idle; allocate reads frames one per cycle from the frame RAM;
// the lowest-free scan reads up to NUM_FRAMES frames, the clock sweep up to NUM_FRAMES + 1.
// One transaction in flight; busy drops in the result cycle, so the next one can start there.
// After reset the frame RAM is cleared with busy high.
`default_nettype none
module frame_alloc_clock_replacement #(
	parameter int NUM_FRAMES = fac_pkg::NUM_FRAMES_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire fac_pkg::req_t req,
	output logic               done,
	output fac_pkg::rsp_t      rsp
);

	localparam int AW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam int CW = $clog2(NUM_FRAMES + 1);
	localparam int EW = $bits(fac_pkg::ent_t);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK,
		S_SCAN,
		S_SWEEP
	} state_t;

	state_t          state_q;
	logic [AW-1:0]   clr_addr_q;
	logic [CW-1:0]   used_cnt_q;
	logic [AW-1:0]   hand_q;
	fac_pkg::req_t   req_q;
	logic [AW-1:0]   rd_addr_q;
	logic [AW-1:0]   chk_addr_s1;
	logic            done_q;
	fac_pkg::rsp_t   rsp_q;

	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	fac_pkg::ent_t   ram_wdata;
	logic [AW-1:0]   ram_raddr;
	logic [EW-1:0]   ram_rdata;
	fac_pkg::ent_t   ent;
	logic [AW-1:0]   req_addr;
	logic            req_in_range;
	logic            pool_full;

	function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] a);
		return (a == AW'(NUM_FRAMES - 1)) ? '0 : a + 1'b1;
	endfunction

	assign ent          = fac_pkg::ent_t'(ram_rdata);
	assign req_addr     = AW'(req.frame_index);
	assign req_in_range = 32'(req.frame_index) < 32'(NUM_FRAMES);
	assign pool_full    = used_cnt_q == CW'(NUM_FRAMES);

	fac_ram #(
		.WIDTH(EW),
		.DEPTH(NUM_FRAMES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(EW'(ram_wdata)),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = chk_addr_s1;
		ram_wdata = '{used: 1'b1, refd: 1'b0};
		ram_raddr = rd_addr_q;
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_addr_q;
				ram_wdata = '{used: 1'b0, refd: 1'b0};
			end
			S_IDLE: begin
				if (req.cmd == fac_pkg::CMD_ALLOC) begin
					ram_raddr = pool_full ? hand_q : '0;
				end else begin
					ram_raddr = req_addr;
				end
			end
			S_LOOK: begin
				if (req_q.cmd == fac_pkg::CMD_FREE) begin
					ram_we    = 1'b1;
					ram_wdata = '{used: 1'b0, refd: 1'b0};
				end else begin
					ram_we    = ent.used;
					ram_wdata = '{used: 1'b1, refd: 1'b1};
				end
			end
			S_SCAN: begin
				ram_we = !ent.used;
			end
			S_SWEEP: begin
				ram_we = 1'b1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_addr_q  <= '0;
			used_cnt_q  <= '0;
			hand_q      <= '0;
			req_q       <= '0;
			rd_addr_q   <= '0;
			chk_addr_s1 <= '0;
			done_q      <= 1'b0;
			rsp_q       <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == AW'(NUM_FRAMES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						req_q <= req;
						rsp_q <= '{granted_frame: req.frame_index, evicted: 1'b0};
						case (req.cmd) inside
							fac_pkg::CMD_ALLOC: begin
								if (pool_full) begin
									chk_addr_s1 <= hand_q;
									rd_addr_q   <= next_slot(hand_q);
									state_q     <= S_SWEEP;
								end else begin
									chk_addr_s1 <= '0;
									rd_addr_q   <= next_slot('0);
									state_q     <= S_SCAN;
								end
							end
							fac_pkg::CMD_FREE, fac_pkg::CMD_MARK: begin
								chk_addr_s1 <= req_addr;
								if (req_in_range) begin
									state_q <= S_LOOK;
								end else begin
									done_q <= 1'b1;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_LOOK: begin
					if (req_q.cmd == fac_pkg::CMD_FREE && ent.used) begin
						used_cnt_q <= used_cnt_q - 1'b1;
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					if (!ent.used) begin
						used_cnt_q <= used_cnt_q + 1'b1;
						rsp_q      <= '{granted_frame: fac_pkg::FRAME_W'(chk_addr_s1),
						                evicted: 1'b0};
						done_q     <= 1'b1;
						state_q    <= S_IDLE;
					end else begin
						chk_addr_s1 <= rd_addr_q;
						rd_addr_q   <= next_slot(rd_addr_q);
					end
				end
				S_SWEEP: begin
					if (!ent.refd) begin
						hand_q  <= next_slot(chk_addr_s1);
						rsp_q   <= '{granted_frame: fac_pkg::FRAME_W'(chk_addr_s1),
						             evicted: 1'b1};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						chk_addr_s1 <= rd_addr_q;
						rd_addr_q   <= next_slot(rd_addr_q);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
`default_nettype wire

### design/fac_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module fac_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 64,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire
